// ===== hdl/stun_xor_mapped_address_parser_core_assert.svh =====
// assertion helpers for the rtl, included by stunxma_back
`ifndef STUN_XOR_MAPPED_ADDRESS_PARSER_CORE_ASSERT_SVH
`define STUN_XOR_MAPPED_ADDRESS_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STUNXMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define STUNXMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/stunxma_pkg.sv =====
package stunxma_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;

  localparam logic [4:0]  HDR_BYTES    = 5'd20;
  localparam logic [4:0]  HDR_LAST_IDX = 5'd19;
  localparam logic [15:0] RESP_TYPE    = 16'h0101;
  localparam logic [15:0] XMA_TYPE     = 16'h0020;
  localparam logic [7:0]  FAMILY_V4    = 8'h01;
  localparam logic [15:0] XMA_MIN_LEN  = 16'd8;
  localparam logic [31:0] COOKIE_RESET = 32'h2112A442;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_TXN        = 3'd2,
    ST_TRUNC      = 3'd3,
    ST_FAMILY     = 3'd4,
    ST_NOT_FOUND  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_TXN_HIGH = 2'd0,
    REG_TXN_MID  = 2'd1,
    REG_TXN_LOW  = 2'd2,
    REG_COOKIE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_ATTR_HDR = 2'b01,
    PH_VALUE    = 2'b10
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] public_port;
    logic [31:0] mapped_address;
  } out_item_t;

  // byte tagged by the front end
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       hdr;
    logic [4:0] hdr_idx;
    logic       txn_ok;
  } tag_t;

endpackage

// ===== hdl/stunxma_fifo.sv =====
module stunxma_fifo import stunxma_pkg::*; #(
  parameter int  Depth = QUEUE_DEPTH,
  parameter type item_t = tag_t
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  item_t          mem [Depth];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = (count_r == CW'(Depth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

endmodule

// ===== hdl/stunxma_front.sv =====
module stunxma_front import stunxma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_item_t    in_item,
  input  logic        q_full,
  input  logic [31:0] txn_high,
  input  logic [31:0] txn_mid,
  input  logic [31:0] txn_low,
  output logic        q_push,
  output tag_t        q_tag
);

  logic [4:0] hcnt_r;
  logic [3:0] txn_i;
  logic [7:0] txn_b [12];
  logic       in_hdr;
  logic [7:0] want;

  assign in_hdr = (hcnt_r < HDR_BYTES);
  assign q_push = in_push && !q_full;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      txn_b[k]     = txn_high[31 - 8*k -: 8];
      txn_b[k + 4] = txn_mid[31 - 8*k -: 8];
      txn_b[k + 8] = txn_low[31 - 8*k -: 8];
    end
  end

  // transaction id sits at header bytes 8..19
  always_comb begin
    txn_i = '0;
    if (hcnt_r >= 5'd8 && in_hdr) begin
      txn_i = 4'(hcnt_r - 5'd8);
    end
  end
  assign want = txn_b[txn_i];

  always_comb begin
    q_tag.data_byte = in_item.data_byte;
    q_tag.last_byte = in_item.last_byte;
    q_tag.hdr       = in_hdr;
    q_tag.hdr_idx   = hcnt_r;
    q_tag.txn_ok    = (want == in_item.data_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= '0;
    end else if (q_push) begin
      if (in_item.last_byte) begin
        hcnt_r <= '0;
      end else if (in_hdr) begin
        hcnt_r <= hcnt_r + 5'd1;
      end
    end
  end

endmodule

// ===== hdl/stunxma_back.sv =====
module stunxma_back import stunxma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tag_valid,
  input  tag_t        tag,
  output logic        tag_pop,
  input  logic [31:0] magic_cookie,
  input  logic        res_full,
  output logic        res_push,
  output out_item_t   res
);

`include "stun_xor_mapped_address_parser_core_assert.svh"

  logic [15:0] type_r, type_nxt;
  logic [31:0] cookie_r, cookie_nxt;
  logic        txn_mis_r, txn_mis_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  ahc_r, ahc_nxt;
  logic [15:0] kind_r, kind_nxt;
  logic [15:0] len_r, len_nxt;
  logic [16:0] vcnt_r, vcnt_nxt, vcnt_inc;
  logic [7:0]  fam_r, fam_nxt;
  logic [15:0] xport_r, xport_nxt;
  logic [31:0] xaddr_r, xaddr_nxt;
  logic        fixed_r, fixed_nxt;
  status_t     code_r, code_nxt;

  logic [16:0] pad_cur, pad_hdr;
  logic        match;
  logic        take;
  logic [7:0]  b;
  logic        verdict_set;

  assign tag_pop  = tag_valid && (!tag.last_byte || !res_full);
  assign res_push = tag_pop && tag.last_byte;
  assign take     = tag_pop && !fixed_r;
  assign b        = tag.data_byte;

  // padded length of the attribute in flight and of the one just completing
  assign pad_cur  = ({1'b0, len_r} + 17'd3) & 17'h1FFFC;
  assign pad_hdr  = ({1'b0, len_r[7:0], b} + 17'd3) & 17'h1FFFC;
  assign match    = (kind_r == XMA_TYPE) && (len_r >= XMA_MIN_LEN);
  assign vcnt_inc = vcnt_r + 17'd1;

  always_comb begin
    type_nxt    = type_r;
    cookie_nxt  = cookie_r;
    txn_mis_nxt = txn_mis_r;
    phase_nxt   = phase_r;
    ahc_nxt     = ahc_r;
    kind_nxt    = kind_r;
    len_nxt     = len_r;
    vcnt_nxt    = vcnt_r;
    fam_nxt     = fam_r;
    xport_nxt   = xport_r;
    xaddr_nxt   = xaddr_r;
    fixed_nxt   = fixed_r;
    code_nxt    = code_r;

    if (take) begin
      if (tag.hdr) begin
        if (tag.hdr_idx < 5'd2) begin
          type_nxt = {type_r[7:0], b};
        end else if (tag.hdr_idx >= 5'd4 && tag.hdr_idx < 5'd8) begin
          cookie_nxt = {cookie_r[23:0], b};
        end else if (tag.hdr_idx >= 5'd8 && !tag.txn_ok) begin
          txn_mis_nxt = 1'b1;
        end
        if (tag.hdr_idx == HDR_LAST_IDX) begin
          if (type_r != RESP_TYPE || cookie_r != magic_cookie) begin
            fixed_nxt = 1'b1;
            code_nxt  = ST_BAD_HEADER;
          end else if (txn_mis_nxt) begin
            fixed_nxt = 1'b1;
            code_nxt  = ST_TXN;
          end else if (tag.last_byte) begin
            fixed_nxt = 1'b1;
            code_nxt  = ST_NOT_FOUND;
          end
        end else if (tag.last_byte) begin
          fixed_nxt = 1'b1;
          code_nxt  = ST_BAD_HEADER;
        end
      end else if (phase_r == PH_VALUE) begin
        if (match) begin
          if (vcnt_r == 17'd1) begin
            fam_nxt = b;
          end else if (vcnt_r == 17'd2 || vcnt_r == 17'd3) begin
            xport_nxt = {xport_r[7:0], b};
          end else if (vcnt_r >= 17'd4 && vcnt_r < 17'd8) begin
            xaddr_nxt = {xaddr_r[23:0], b};
          end
        end
        vcnt_nxt = vcnt_inc;
        if (vcnt_inc == pad_cur) begin
          priority if (match) begin
            fixed_nxt = 1'b1;
            code_nxt  = (fam_nxt == FAMILY_V4) ? ST_OK : ST_FAMILY;
          end else if (tag.last_byte) begin
            fixed_nxt = 1'b1;
            code_nxt  = ST_NOT_FOUND;
          end else begin
            phase_nxt = PH_ATTR_HDR;
            kind_nxt  = '0;
            len_nxt   = '0;
          end
        end else if (tag.last_byte) begin
          fixed_nxt = 1'b1;
          code_nxt  = ST_TRUNC;
        end
      end else begin
        if (!ahc_r[1]) begin
          kind_nxt = {kind_r[7:0], b};
        end else begin
          len_nxt = {len_r[7:0], b};
        end
        if (ahc_r != 2'd3) begin
          ahc_nxt = ahc_r + 2'd1;
          if (tag.last_byte) begin
            fixed_nxt = 1'b1;
            code_nxt  = ST_NOT_FOUND;
          end
        end else begin
          ahc_nxt = '0;
          priority if (pad_hdr == '0) begin
            if (tag.last_byte) begin
              fixed_nxt = 1'b1;
              code_nxt  = ST_NOT_FOUND;
            end
          end else if (tag.last_byte) begin
            fixed_nxt = 1'b1;
            code_nxt  = ST_TRUNC;
          end else begin
            phase_nxt = PH_VALUE;
            vcnt_nxt  = '0;
          end
        end
      end
    end

    verdict_set = fixed_nxt;

    res.status = code_nxt;
    if (code_nxt == ST_OK) begin
      res.public_port    = xport_nxt ^ magic_cookie[31:16];
      res.mapped_address = xaddr_nxt ^ magic_cookie;
    end else begin
      res.public_port    = '0;
      res.mapped_address = '0;
    end

    // datagram done: parse state back to its start
    if (res_push) begin
      type_nxt    = '0;
      cookie_nxt  = '0;
      txn_mis_nxt = 1'b0;
      phase_nxt   = PH_ATTR_HDR;
      ahc_nxt     = '0;
      kind_nxt    = '0;
      len_nxt     = '0;
      vcnt_nxt    = '0;
      fam_nxt     = '0;
      xport_nxt   = '0;
      xaddr_nxt   = '0;
      fixed_nxt   = 1'b0;
      code_nxt    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r    <= '0;
      cookie_r  <= '0;
      txn_mis_r <= 1'b0;
      phase_r   <= PH_ATTR_HDR;
      ahc_r     <= '0;
      kind_r    <= '0;
      len_r     <= '0;
      vcnt_r    <= '0;
      fam_r     <= '0;
      xport_r   <= '0;
      xaddr_r   <= '0;
      fixed_r   <= 1'b0;
      code_r    <= ST_OK;
    end else begin
      type_r    <= type_nxt;
      cookie_r  <= cookie_nxt;
      txn_mis_r <= txn_mis_nxt;
      phase_r   <= phase_nxt;
      ahc_r     <= ahc_nxt;
      kind_r    <= kind_nxt;
      len_r     <= len_nxt;
      vcnt_r    <= vcnt_nxt;
      fam_r     <= fam_nxt;
      xport_r   <= xport_nxt;
      xaddr_r   <= xaddr_nxt;
      fixed_r   <= fixed_nxt;
      code_r    <= code_nxt;
    end
  end

  `STUNXMA_ASSERT_NOW(a_last_has_verdict, take && tag.last_byte, verdict_set,
    "last byte left no verdict")
  `STUNXMA_ASSERT_NEXT(a_restart, res_push,
    !fixed_r && phase_r == PH_ATTR_HDR && ahc_r == 2'd0,
    "parse state not cleared after result")
  `STUNXMA_ASSERT_NEXT(a_verdict_holds, fixed_r && !res_push, fixed_r && $stable(code_r),
    "fixed verdict changed before last byte")
  `STUNXMA_ASSERT_NOW(a_no_value_in_hdr, tag_valid && tag.hdr,
    phase_r == PH_ATTR_HDR && ahc_r == 2'd0,
    "header byte seen with attribute parse in progress")

endmodule

// ===== hdl/stun_xor_mapped_address_parser_core.sv =====
// Parses a STUN binding response fed one datagram byte per clock (last byte flagged) and
// returns one status with the XOR-MAPPED-ADDRESS port and IPv4 address per datagram.
// Throughput is one byte per clock sustained while the result queue has room. A front end
// tags header position and transaction-id matches and feeds a QueueDepth-entry queue; the
// parser drains it and writes results into an OutDepth-entry result queue, so a result is
// pushed as its last byte is taken and shows on out_item once earlier results are popped.
// in_full rises only when the byte queue fills, which happens while a result waits for
// pop with the result queue full. Configuration must be written between datagrams.
module stun_xor_mapped_address_parser_core import stunxma_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH,
  parameter int OutDepth   = OUT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_item,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  cfg_reg_t    cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] txn_high_r, txn_mid_r, txn_low_r, cookie_r;

  logic      q_push, q_full, q_empty, q_pop;
  tag_t      q_wtag, q_rtag;
  logic      res_push, res_full;
  out_item_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txn_high_r <= '0;
      txn_mid_r  <= '0;
      txn_low_r  <= '0;
      cookie_r   <= COOKIE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TXN_HIGH: txn_high_r <= cfg_wdata;
        REG_TXN_MID:  txn_mid_r  <= cfg_wdata;
        REG_TXN_LOW:  txn_low_r  <= cfg_wdata;
        REG_COOKIE:   cookie_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = q_full;

  stunxma_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .q_full   (q_full),
    .txn_high (txn_high_r),
    .txn_mid  (txn_mid_r),
    .txn_low  (txn_low_r),
    .q_push   (q_push),
    .q_tag    (q_wtag)
  );

  stunxma_fifo #(
    .Depth  (QueueDepth),
    .item_t (tag_t)
  ) u_tagq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wtag),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rtag),
    .empty (q_empty)
  );

  stunxma_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .tag_valid    (!q_empty),
    .tag          (q_rtag),
    .tag_pop      (q_pop),
    .magic_cookie (cookie_r),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res)
  );

  stunxma_fifo #(
    .Depth  (OutDepth),
    .item_t (out_item_t)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

// ===== verif/stun_xor_mapped_address_parser_core_tb.sv =====
module stun_xor_mapped_address_parser_core_tb;
  import stunxma_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 190;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       typed;
    out_item_t  want;
  } dir_row_t;

  // short datagrams, then one clean header with no attributes at reset values
  localparam dir_row_t DIRECTED_ROWS [24] = '{
    '{8'h00, 1'b1, 1'b1, '{ST_BAD_HEADER, 16'h0, 32'h0}},
    '{8'hFF, 1'b1, 1'b1, '{ST_BAD_HEADER, 16'h0, 32'h0}},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h01, 1'b1, 1'b1, '{ST_BAD_HEADER, 16'h0, 32'h0}},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h21, 1'b0, 1'b0, '0},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'hA4, 1'b0, 1'b0, '0},
    '{8'h42, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{ST_NOT_FOUND, 16'h0, 32'h0}}
  };

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_push   = 1'b0;
  logic        in_full;
  in_item_t    in_item   = '0;
  logic        out_empty;
  logic        out_pop   = 1'b0;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  cfg_reg_t    cfg_index = REG_TXN_HIGH;
  logic [31:0] cfg_wdata = '0;

  stun_xor_mapped_address_parser_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // register copies
  logic [31:0] txn_hi, txn_mid, txn_lo, cookie_reg;

  // datagram parse state
  logic [4:0]  hdr_pos;
  logic [15:0] msg_type;
  logic [31:0] rx_cookie;
  logic        txn_bad;
  logic        in_value;
  logic [1:0]  tlv_hdr_pos;
  logic [15:0] tlv_type;
  logic [15:0] tlv_len;
  logic [16:0] val_pos;
  logic [7:0]  fam;
  logic [15:0] port_x;
  logic [31:0] addr_x;
  logic        decided;
  status_t     verdict;

  out_item_t   awaited_results [$];
  logic [7:0]  dgram [$];
  int          fail_count = 0;
  int          in_idle_pct = 0;
  int          pop_idle_pct = 0;
  int          pop_hold = 0;
  int          quiet_cycles = 0;

  function automatic void clear_parse_state();
    hdr_pos = '0; msg_type = '0; rx_cookie = '0; txn_bad = 1'b0;
    in_value = 1'b0; tlv_hdr_pos = '0; tlv_type = '0; tlv_len = '0;
    val_pos = '0; fam = '0; port_x = '0; addr_x = '0;
    decided = 1'b0; verdict = ST_OK;
  endfunction

  function automatic void settle_verdict(status_t code);
    decided = 1'b1;
    verdict = code;
  endfunction

  // advances the parse by one datagram byte; a flagged byte yields the status
  function automatic void decode_byte(input logic [7:0] b, input logic eop,
                                      output bit has_res, output out_item_t res);
    int          i;
    logic [31:0] word;
    logic [16:0] padded;
    bit          is_xma;
    has_res = 1'b0;
    res = '0;
    if (!decided) begin
      if (hdr_pos < HDR_BYTES) begin
        i = int'(hdr_pos);
        if (i < 2) msg_type = {msg_type[7:0], b};
        else if (i >= 4 && i < 8) rx_cookie = {rx_cookie[23:0], b};
        else if (i >= 8) begin
          word = (i < 12) ? txn_hi : (i < 16) ? txn_mid : txn_lo;
          if (word[31 - 8 * ((i - 8) % 4) -: 8] != b) txn_bad = 1'b1;
        end
        hdr_pos = hdr_pos + 5'd1;
        if (hdr_pos == HDR_BYTES) begin
          if (msg_type != RESP_TYPE || rx_cookie != cookie_reg) settle_verdict(ST_BAD_HEADER);
          else if (txn_bad) settle_verdict(ST_TXN);
          else if (eop) settle_verdict(ST_NOT_FOUND);
        end else if (eop) begin
          settle_verdict(ST_BAD_HEADER);
        end
      end else if (in_value) begin
        padded = ({1'b0, tlv_len} + 17'd3) & 17'h1FFFC;
        is_xma = (tlv_type == XMA_TYPE) && (tlv_len >= XMA_MIN_LEN);
        if (is_xma) begin
          if (val_pos == 17'd1) fam = b;
          else if (val_pos == 17'd2 || val_pos == 17'd3) port_x = {port_x[7:0], b};
          else if (val_pos >= 17'd4 && val_pos < 17'd8) addr_x = {addr_x[23:0], b};
        end
        val_pos = val_pos + 17'd1;
        if (val_pos == padded) begin
          if (is_xma) settle_verdict(fam == FAMILY_V4 ? ST_OK : ST_FAMILY);
          else if (eop) settle_verdict(ST_NOT_FOUND);
          else begin
            in_value = 1'b0;
            tlv_type = '0;
            tlv_len = '0;
          end
        end else if (eop) begin
          settle_verdict(ST_TRUNC);
        end
      end else begin
        if (tlv_hdr_pos < 2'd2) tlv_type = {tlv_type[7:0], b};
        else tlv_len = {tlv_len[7:0], b};
        if (tlv_hdr_pos != 2'd3) begin
          tlv_hdr_pos = tlv_hdr_pos + 2'd1;
          if (eop) settle_verdict(ST_NOT_FOUND);
        end else begin
          tlv_hdr_pos = '0;
          padded = ({1'b0, tlv_len} + 17'd3) & 17'h1FFFC;
          if (padded == '0) begin
            if (eop) settle_verdict(ST_NOT_FOUND);
          end else if (eop) begin
            settle_verdict(ST_TRUNC);
          end else begin
            in_value = 1'b1;
            val_pos = '0;
          end
        end
      end
    end
    if (eop) begin
      has_res = 1'b1;
      res.status = verdict;
      if (verdict == ST_OK) begin
        res.public_port = port_x ^ cookie_reg[31:16];
        res.mapped_address = addr_x ^ cookie_reg;
      end
      clear_parse_state();
    end
  endfunction

  // mostly well-formed responses with random content, some noise and cut datagrams
  function automatic void build_datagram();
    int          nattr, sel, padded, count, cut, hdr_mode;
    logic [15:0] t, alen, mlen;
    logic [31:0] ck;
    logic [95:0] tid;
    logic [7:0]  b;
    bit          big;
    dgram.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 40)) dgram.push_back(8'($urandom));
      return;
    end
    hdr_mode = $urandom_range(0, 15);
    t = (hdr_mode == 0 || hdr_mode == 3) ? 16'($urandom) : RESP_TYPE;
    ck = (hdr_mode == 1) ? cookie_reg ^ (32'd1 << $urandom_range(0, 31)) : cookie_reg;
    tid = {txn_hi, txn_mid, txn_lo};
    if (hdr_mode == 2 || hdr_mode == 3)
      tid[8 * $urandom_range(0, 11) +: 8] ^= 8'($urandom_range(1, 255));
    mlen = 16'($urandom);
    dgram.push_back(t[15:8]);
    dgram.push_back(t[7:0]);
    dgram.push_back(mlen[15:8]);
    dgram.push_back(mlen[7:0]);
    for (int k = 0; k < 4; k++) dgram.push_back(ck[31 - 8 * k -: 8]);
    for (int k = 0; k < 12; k++) dgram.push_back(tid[95 - 8 * k -: 8]);
    nattr = $urandom_range(0, 3);
    for (int a = 0; a < nattr; a++) begin
      sel = $urandom_range(0, 9);
      big = 1'b0;
      if (sel < 5) begin
        t = XMA_TYPE;
        case ($urandom_range(0, 9))
          0:       alen = 16'($urandom_range(0, 7));
          1, 2:    alen = 16'($urandom_range(9, 20));
          default: alen = XMA_MIN_LEN;
        endcase
      end else if (sel < 9) begin
        t = 16'($urandom);
        alen = 16'($urandom_range(0, 12));
      end else begin
        // random length, often huge: a value over 16 bytes is sent only in part and no attribute follows
        t = 16'($urandom);
        alen = 16'($urandom);
        big = 1'b1;
      end
      dgram.push_back(t[15:8]);
      dgram.push_back(t[7:0]);
      dgram.push_back(alen[15:8]);
      dgram.push_back(alen[7:0]);
      padded = ((int'(alen) + 3) / 4) * 4;
      count = padded;
      if (big) count = (padded < 16) ? padded : $urandom_range(0, 16);
      for (int k = 0; k < count; k++) begin
        b = 8'($urandom);
        if (t == XMA_TYPE && k == 1 && $urandom_range(0, 4) != 0) b = FAMILY_V4;
        dgram.push_back(b);
      end
      if (big) break;
    end
    case ($urandom_range(0, 9))
      0, 1: begin
        cut = $urandom_range(1, dgram.size());
        while (dgram.size() > cut) void'(dgram.pop_back());
      end
      2: repeat ($urandom_range(1, 3)) dgram.push_back(8'($urandom));
      default: ;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eop,
                           input logic typed, input out_item_t typed_want);
    bit        has_res;
    out_item_t res;
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= '{data_byte: b, last_byte: eop};
    @(posedge clk);
    while (in_full) @(posedge clk);
    decode_byte(b, eop, has_res, res);
    if (has_res) begin
      awaited_results.push_back(typed ? typed_want : res);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_TXN_HIGH: txn_hi = val;
      REG_TXN_MID:  txn_mid = val;
      REG_TXN_LOW:  txn_lo = val;
      REG_COOKIE:   cookie_reg = val;
      default: ;
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      $error("result with no request pending: status %0d", got.status);
      fail_count++;
      return;
    end
    want = awaited_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.public_port !== want.public_port) begin
      $error("public_port: expected %h, got %h", want.public_port, got.public_port);
      fail_count++;
    end
    if (got.mapped_address !== want.mapped_address) begin
      $error("mapped_address: expected %h, got %h", want.mapped_address, got.mapped_address);
      fail_count++;
    end
  endtask

  // result side: check and throttle pop in random bursts
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) check_result(out_item);
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else if ($urandom_range(0, 99) < pop_idle_pct) begin
      out_pop <= 1'b0;
      pop_hold = $urandom_range(1, 9) - 1;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_items;
    logic [31:0] new_hi, new_mid, new_lo, new_cookie;
    txn_hi = '0;
    txn_mid = '0;
    txn_lo = '0;
    cookie_reg = COOKIE_RESET;
    clear_parse_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 25;
    pop_idle_pct = 25;
    for (int r = 0; r < 24; r++)
      send_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].eop,
                DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    in_push <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // registers change only between datagrams with the pipe empty
      while (awaited_results.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      new_hi = $urandom;
      new_mid = $urandom;
      new_lo = $urandom;
      new_cookie = $urandom;
      case (ph)
        0: begin
          new_hi = '0; new_mid = '0; new_lo = '0; new_cookie = '0;
          in_idle_pct = 20; pop_idle_pct = 20;
        end
        1: begin
          new_hi = '1; new_mid = '1; new_lo = '1; new_cookie = '1;
          in_idle_pct = 0; pop_idle_pct = 40;
        end
        2: begin
          in_idle_pct = 40; pop_idle_pct = 0;
        end
        3: begin
          new_cookie = COOKIE_RESET;
          in_idle_pct = 15; pop_idle_pct = 15;
        end
        4: begin
          in_idle_pct = 30; pop_idle_pct = 30;
        end
        default: begin
          in_idle_pct = 0; pop_idle_pct = 0;
        end
      endcase
      write_reg(REG_TXN_HIGH, new_hi);
      write_reg(REG_TXN_MID, new_mid);
      write_reg(REG_TXN_LOW, new_lo);
      write_reg(REG_COOKIE, new_cookie);
      cfg_we <= 1'b0;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_datagram();
        foreach (dgram[k]) send_byte(dgram[k], k == dgram.size() - 1, 1'b0, '0);
        phase_items += dgram.size();
      end
      in_push <= 1'b0;
    end

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== stun_xor_mapped_address_parser_core.f =====
+incdir+hdl
hdl/stunxma_pkg.sv
hdl/stunxma_fifo.sv
hdl/stunxma_front.sv
hdl/stunxma_back.sv
hdl/stun_xor_mapped_address_parser_core.sv
verif/stun_xor_mapped_address_parser_core_tb.sv
